>>> rtl/core/dsfmc_pkg.sv
// ============================================================================
// dsfmc_pkg
// Types and constants shared by the particle-sensor frame parser and the
// measuring-mode command generator.
// ============================================================================
package dsfmc_pkg;

  // Frame layout
  localparam logic [4:0] FRAME_LAST_IDX  = 5'd21;
  localparam logic [4:0] IDX_STATUS      = 5'd2;
  localparam logic [4:0] IDX_PM25_HI     = 5'd5;
  localparam logic [4:0] IDX_PM25_LO     = 5'd6;
  localparam logic [4:0] IDX_PM10_HI     = 5'd7;
  localparam logic [4:0] IDX_PM10_LO     = 5'd8;
  localparam logic [4:0] IDX_MODE_HI     = 5'd9;
  localparam logic [4:0] IDX_MODE_LO     = 5'd10;

  // Interval policy
  localparam logic [15:0] INTERVAL_DEFAULT   = 16'd360;
  localparam logic [15:0] INTERVAL_TIMED_MIN = 16'd300;
  localparam logic [15:0] INTERVAL_MAX       = 16'd60000;
  localparam logic [15:0] MODE_WORD_DYNAMIC  = 16'd5;

  // Command bytes
  localparam logic [7:0] CMD_HDR0       = 8'h50;
  localparam logic [7:0] CMD_HDR1       = 8'h16;
  localparam logic [7:0] CMD_HDR2       = 8'h07;
  localparam logic [7:0] CMD_OP_DYNAMIC = 8'h05;
  localparam logic [7:0] CMD_OP_TIMING  = 8'h04;

  // Beat index within one frame's run: beat 0 is the reading, 1..8 the command.
  localparam logic [3:0] BEAT_LAST_CMD = 4'd8;

  // Register map (word index)
  typedef enum logic [1:0] {
    REG_ACTIVE_INTERVAL = 2'd0,
    REG_QUIET_INTERVAL  = 2'd1,
    REG_QUIET_ENABLED   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_DYNAMIC = 2'd1,
    CMD_TIMING  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [15:0] active_interval_s;
    logic [15:0] quiet_interval_s;
    logic        quiet_enabled;
  } cfg_t;

  // One finished frame, handed from the parser to the command generator.
  typedef struct packed {
    logic        frame_ok;
    logic [7:0]  sensor_status;
    logic [15:0] pm25_value;
    logic [15:0] pm10_value;
    logic [15:0] measure_mode;
    logic [15:0] interval_used;
    cmd_kind_t   cmd_kind;
    logic [7:0]  cmd_hi;
    logic [7:0]  cmd_lo;
  } job_t;

endpackage

>>> rtl/core/dsfmc_if.sv
// ============================================================================
// dsfmc_if
// Valid/ready channels for received frame bytes and for result beats.
// ============================================================================
interface dsfmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;
  logic       in_quiet_period;

  modport source (output valid, output rx_byte, output frame_start,
                  output in_quiet_period, input ready);
  modport sink (input valid, input rx_byte, input frame_start,
                input in_quiet_period, output ready);
endinterface

interface dsfmc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        frame_ok;
  logic [7:0]  sensor_status;
  logic [15:0] pm25_value;
  logic [15:0] pm10_value;
  logic [15:0] measure_mode;
  logic [15:0] interval_used;
  logic [7:0]  cmd_byte;
  logic        last_of_run;

  modport source (output valid, output result_kind, output frame_ok,
                  output sensor_status, output pm25_value, output pm10_value,
                  output measure_mode, output interval_used, output cmd_byte,
                  output last_of_run, input ready);
  modport sink (input valid, input result_kind, input frame_ok,
                input sensor_status, input pm25_value, input pm10_value,
                input measure_mode, input interval_used, input cmd_byte,
                input last_of_run, output ready);
endinterface

>>> rtl/core/dsfmc_cfg_regs.sv
// ============================================================================
// dsfmc_cfg_regs
// APB register file holding the active and quiet intervals and the
// quiet-hours enable.
// ============================================================================
module dsfmc_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output dsfmc_pkg::cfg_t    cfg
);
  import dsfmc_pkg::*;

  logic [15:0] active_r;
  logic [15:0] quiet_r;
  logic        quiet_en_r;
  logic        wr_en;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= '0;
      quiet_r    <= '0;
      quiet_en_r <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ACTIVE_INTERVAL: active_r   <= pwdata[15:0];
        REG_QUIET_INTERVAL:  quiet_r    <= pwdata[15:0];
        REG_QUIET_ENABLED:   quiet_en_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACTIVE_INTERVAL: prdata = {16'd0, active_r};
      REG_QUIET_INTERVAL:  prdata = {16'd0, quiet_r};
      REG_QUIET_ENABLED:   prdata = {31'd0, quiet_en_r};
      default:             prdata = '0;
    endcase
  end

  assign cfg.active_interval_s = active_r;
  assign cfg.quiet_interval_s  = quiet_r;
  assign cfg.quiet_enabled     = quiet_en_r;

endmodule

>>> rtl/core/dsfmc_front.sv
// ============================================================================
// dsfmc_front
// Frame parser: counts bytes, folds the checksum, captures the frame fields
// and, on the checksum byte, decides the interval and the mode command.
// ============================================================================
module dsfmc_front (
  input  logic               clk,
  input  logic               rst_n,
  dsfmc_in_if.sink           in_ch,
  input  dsfmc_pkg::cfg_t    cfg,
  input  logic               q_full,
  output logic               q_push,
  output dsfmc_pkg::job_t    q_job
);
  import dsfmc_pkg::*;

  logic [4:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  xor_sum_r, xor_sum_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [15:0] pm25_r, pm25_nxt;
  logic [15:0] pm10_r, pm10_nxt;
  logic [15:0] mode_r, mode_nxt;

  logic        accept;
  logic [4:0]  idx;
  logic [7:0]  xs;
  logic        is_last;
  logic        sum_ok;
  logic [15:0] interval;
  logic [15:0] clamped;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign idx         = in_ch.frame_start ? 5'd0 : byte_index_r;
  assign xs          = in_ch.frame_start ? 8'd0 : xor_sum_r;
  assign is_last     = (idx == FRAME_LAST_IDX);
  assign sum_ok      = (xs == in_ch.rx_byte);

  always_comb begin
    byte_index_nxt = byte_index_r;
    xor_sum_nxt    = xor_sum_r;
    status_nxt     = status_r;
    pm25_nxt       = pm25_r;
    pm10_nxt       = pm10_r;
    mode_nxt       = mode_r;
    if (accept) begin
      if (is_last) begin
        byte_index_nxt = '0;
        xor_sum_nxt    = '0;
      end else begin
        byte_index_nxt = idx + 5'd1;
        xor_sum_nxt    = xs ^ in_ch.rx_byte;
        if (idx == IDX_STATUS)  status_nxt      = in_ch.rx_byte;
        if (idx == IDX_PM25_HI) pm25_nxt[15:8]  = in_ch.rx_byte;
        if (idx == IDX_PM25_LO) pm25_nxt[7:0]   = in_ch.rx_byte;
        if (idx == IDX_PM10_HI) pm10_nxt[15:8]  = in_ch.rx_byte;
        if (idx == IDX_PM10_LO) pm10_nxt[7:0]   = in_ch.rx_byte;
        if (idx == IDX_MODE_HI) mode_nxt[15:8]  = in_ch.rx_byte;
        if (idx == IDX_MODE_LO) mode_nxt[7:0]   = in_ch.rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      xor_sum_r    <= '0;
      status_r     <= '0;
      pm25_r       <= '0;
      pm10_r       <= '0;
      mode_r       <= '0;
    end else begin
      byte_index_r <= byte_index_nxt;
      xor_sum_r    <= xor_sum_nxt;
      status_r     <= status_nxt;
      pm25_r       <= pm25_nxt;
      pm10_r       <= pm10_nxt;
      mode_r       <= mode_nxt;
    end
  end

  // With quiet hours configured the register is taken as is, zero included.
  always_comb begin
    if (cfg.quiet_enabled) begin
      interval = in_ch.in_quiet_period ? cfg.quiet_interval_s : cfg.active_interval_s;
    end else begin
      interval = (cfg.active_interval_s == 16'd0) ? INTERVAL_DEFAULT
                                                  : cfg.active_interval_s;
    end
    clamped = (interval > INTERVAL_MAX) ? INTERVAL_MAX : interval;
  end

  always_comb begin
    q_job.frame_ok      = sum_ok;
    q_job.sensor_status = status_r;
    q_job.pm25_value    = pm25_r;
    q_job.pm10_value    = pm10_r;
    q_job.measure_mode  = mode_r;
    q_job.interval_used = sum_ok ? interval : 16'd0;
    q_job.cmd_hi        = clamped[15:8];
    q_job.cmd_lo        = clamped[7:0];
    priority if (!sum_ok) begin
      q_job.cmd_kind = CMD_NONE;
    end else if (interval < INTERVAL_TIMED_MIN && mode_r != MODE_WORD_DYNAMIC) begin
      q_job.cmd_kind = CMD_DYNAMIC;
    end else if (interval >= INTERVAL_TIMED_MIN && mode_r != interval) begin
      q_job.cmd_kind = CMD_TIMING;
    end else begin
      q_job.cmd_kind = CMD_NONE;
    end
  end

  assign q_push = accept && is_last;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= FRAME_LAST_IDX)
    else $error("byte counter ran past the checksum byte");

endmodule

>>> rtl/core/dsfmc_queue.sv
// ============================================================================
// dsfmc_queue
// Short FIFO of finished frames between the parser and the command generator.
// ============================================================================
module dsfmc_queue #(
  parameter int Depth = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dsfmc_pkg::job_t    push_job,
  input  logic               pop,
  output dsfmc_pkg::job_t    head,
  output logic               empty,
  output logic               full
);
  import dsfmc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CntFull);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("frame pushed into a full queue");

endmodule

>>> rtl/core/dsfmc_back.sv
// ============================================================================
// dsfmc_back
// Result generator: turns each queued frame into a reading beat and, when
// needed, the eight beats of the mode command, through an output register.
// ============================================================================
module dsfmc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  dsfmc_pkg::job_t    head,
  input  logic               q_empty,
  output logic               q_pop,
  dsfmc_out_if.source        out_ch
);
  import dsfmc_pkg::*;

  logic [3:0]  seq_r, seq_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        kind_r, ok_r, last_r;
  logic [7:0]  status_r, cmd_r;
  logic [15:0] pm25_r, pm10_r, mode_r, interval_r;

  logic        slot_free;
  logic        load;
  logic        beat_last;
  logic [7:0]  op_byte;
  logic [7:0]  hi_byte;
  logic [7:0]  lo_byte;
  logic [7:0]  cks;
  logic [7:0]  beat_byte;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign load      = slot_free && !q_empty;
  assign beat_last = ((seq_r == 4'd0) && (head.cmd_kind == CMD_NONE))
                     || (seq_r == BEAT_LAST_CMD);
  assign q_pop     = load && beat_last;

  // Only the timing command carries the interval; the dynamic one sends zeros.
  assign op_byte = (head.cmd_kind == CMD_TIMING) ? CMD_OP_TIMING : CMD_OP_DYNAMIC;
  assign hi_byte = (head.cmd_kind == CMD_TIMING) ? head.cmd_hi : 8'd0;
  assign lo_byte = (head.cmd_kind == CMD_TIMING) ? head.cmd_lo : 8'd0;
  assign cks     = CMD_HDR1 ^ CMD_HDR2 ^ op_byte ^ hi_byte ^ lo_byte;

  always_comb begin
    unique case (seq_r)
      4'd1:    beat_byte = CMD_HDR0;
      4'd2:    beat_byte = CMD_HDR1;
      4'd3:    beat_byte = CMD_HDR2;
      4'd4:    beat_byte = op_byte;
      4'd5:    beat_byte = hi_byte;
      4'd6:    beat_byte = lo_byte;
      4'd8:    beat_byte = cks;
      default: beat_byte = 8'd0;
    endcase
  end

  always_comb begin
    seq_nxt       = seq_r;
    out_valid_nxt = out_valid_r;
    if (slot_free) out_valid_nxt = !q_empty;
    if (load) seq_nxt = beat_last ? 4'd0 : seq_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r     <= (seq_r != 4'd0);
      ok_r       <= head.frame_ok;
      status_r   <= head.sensor_status;
      pm25_r     <= head.pm25_value;
      pm10_r     <= head.pm10_value;
      mode_r     <= head.measure_mode;
      interval_r <= head.interval_used;
      cmd_r      <= beat_byte;
      last_r     <= beat_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = kind_r;
  assign out_ch.frame_ok      = ok_r;
  assign out_ch.sensor_status = status_r;
  assign out_ch.pm25_value    = pm25_r;
  assign out_ch.pm10_value    = pm10_r;
  assign out_ch.measure_mode  = mode_r;
  assign out_ch.interval_used = interval_r;
  assign out_ch.cmd_byte      = cmd_r;
  assign out_ch.last_of_run   = last_r;

  a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r <= BEAT_LAST_CMD)
    else $error("command beat counter out of range");

  a_seq_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r != 4'd0) |-> (!q_empty && head.frame_ok && head.cmd_kind != CMD_NONE))
    else $error("command run in progress without a good frame at the queue head");

  a_cmd_beat_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r) |-> ok_r)
    else $error("command beat issued for a frame with a bad checksum");

endmodule

>>> rtl/core/dust_sensor_frame_and_mode_control_top.sv
// ============================================================================
// dust_sensor_frame_and_mode_control_top
// Particle-sensor reading-frame parser with measuring-mode command control.
// ============================================================================
// Usage:
// The in_ch channel carries one received byte of the sensor's 22-byte reading
// frame per beat. frame_start marks byte 0 and restarts a partial frame;
// without it the stream is cut into 22-byte frames. in_quiet_period is only
// looked at on the checksum byte (byte 21).
// The out_ch channel carries results. The checksum byte of each frame causes
// one reading beat; after a good frame whose reported mode does not match the
// chosen interval, eight command beats follow. last_of_run marks the final
// beat of each run.
// Throughput: one input byte per cycle while the queue is not full. A frame's
// run of one or nine beats leaves through the output register at one beat per
// cycle while the receiver is ready, so then a 22-byte frame never backs up
// the parser. The reading beat passes through the queue and then the output
// register before it is valid on out_ch.
// The parser and the result generator are joined by a queue of QueueDepth
// finished frames. When the receiver stalls, out_ch holds its beat, the queue
// fills, and in_ch.ready drops only once the queue is full.
// Reset (rst_n low, synchronous) clears the byte count, checksum, captured
// fields, queue and registers; the configuration port is APB with pready
// always high, registers at byte addresses 0, 4 and 8.
// ============================================================================
module dust_sensor_frame_and_mode_control_top #(
  parameter int QueueDepth = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  dsfmc_in_if.sink    in_ch,
  dsfmc_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dsfmc_pkg::*;

  cfg_t cfg;
  job_t push_job;
  job_t head;
  logic q_push, q_pop, q_empty, q_full;

  // The user changes configuration only while the block is idle; unenforced.
  dsfmc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front: parses bytes and classifies each finished frame.
  dsfmc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  // Queue of finished frames waiting for their result runs.
  dsfmc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back: expands each frame into its reading beat and command beats.
  dsfmc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
